// ----- design/ekv_pkg.sv -----
// ----------------------------------------------------------------------------
// ekv_pkg: shared codes and types of the expiring key/value table
// Command and status codes, and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ekv_pkg;

  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_GET  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EXPIRED   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;       // input beat taken: latch fields, rewind scan
    logic tick;       // advance seconds counter
    logic res_ok;     // result: ok, zero value
    logic res_full;   // result: table full
    logic set_probe;  // set scan: test slot, store if free
    logic get_issue;  // get scan: read entry at scan index
    logic get_check;  // get: judge best match, expire or return value
    logic out_load;   // move result into output register
  } ekv_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic full;       // entry count at capacity
    logic slot_free;  // slot at scan index is empty
    logic scan_last;  // scan index at last slot
    logic out_free;   // output register can take a result
  } ekv_stat_t;

endpackage

// ----- design/ekv_ctrl.sv -----
// ----------------------------------------------------------------------------
// ekv_ctrl: command sequencer of the expiring key/value table
// Takes one input beat at a time and steps the datapath through the slot
// scan of a set or get, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ekv_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_cmd,
  output logic             in_ready,
  input  ekv_pkg::ekv_stat_t stat,
  output ekv_pkg::ekv_ctl_t  ctl
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SET_SCAN  = 6'b000010,
    S_GET_SCAN  = 6'b000100,
    S_GET_DRAIN = 6'b001000,
    S_GET_CHECK = 6'b010000,
    S_FINISH    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          priority if (in_cmd == ekv_pkg::CMD_SET) begin
            if (stat.full) begin
              ctl.res_full = 1'b1;
              state_nxt    = S_FINISH;
            end else begin
              state_nxt = S_SET_SCAN;
            end
          end else if (in_cmd == ekv_pkg::CMD_GET) begin
            state_nxt = S_GET_SCAN;
          end else if (in_cmd == ekv_pkg::CMD_TICK) begin
            ctl.tick   = 1'b1;
            ctl.res_ok = 1'b1;
            state_nxt  = S_FINISH;
          end else begin
            ctl.res_ok = 1'b1;
            state_nxt  = S_FINISH;
          end
        end
      end
      S_SET_SCAN: begin
        // a free slot exists since the table is not full
        ctl.set_probe = 1'b1;
        if (stat.slot_free) begin
          ctl.res_ok = 1'b1;
          state_nxt  = S_FINISH;
        end
      end
      S_GET_SCAN: begin
        ctl.get_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_GET_DRAIN;
        end
      end
      S_GET_DRAIN: begin
        // last read beat is compared this cycle
        state_nxt = S_GET_CHECK;
      end
      S_GET_CHECK: begin
        ctl.get_check = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/ekv_datapath.sv -----
// ----------------------------------------------------------------------------
// ekv_datapath: entry store, scan and result logic of the key/value table
// Entry fields sit in single-port memories with registered reads; valid
// bits, counters and the best-match tracker are flip-flops.
// ----------------------------------------------------------------------------
module ekv_datapath #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ekv_pkg::ekv_ctl_t  ctl,
  output ekv_pkg::ekv_stat_t stat,
  input  logic [31:0]        in_key,
  input  logic [63:0]        in_new_value,
  input  logic [31:0]        in_lifespan,
  input  logic [3:0]         in_byte_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [63:0]        out_read_value
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = 8 * VALUE_BYTES;
  localparam logic [3:0] VB4 = 4'(VALUE_BYTES);

  // entry memories
  logic [31:0]   mem_key   [CAPACITY];
  logic [VW-1:0] mem_value [CAPACITY];
  logic [31:0]   mem_life  [CAPACITY];
  logic [31:0]   mem_start [CAPACITY];
  logic [31:0]   mem_order [CAPACITY];

  logic [CAPACITY-1:0] valid_r;
  logic [CW-1:0]       count_r;
  logic [31:0]         elapsed_r;
  logic [31:0]         serial_r;
  logic [IW-1:0]       idx_r;

  // latched command fields
  logic [31:0]   key_r;
  logic [VW-1:0] value_r;
  logic [31:0]   life_r;
  logic [3:0]    limit_r;

  // read beat
  logic          rd_act_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic [31:0]   rd_key_r;
  logic [VW-1:0] rd_value_r;
  logic [31:0]   rd_life_r;
  logic [31:0]   rd_start_r;
  logic [31:0]   rd_order_r;

  // best match so far
  logic          best_found_r;
  logic [IW-1:0] best_idx_r;
  logic [31:0]   best_order_r;
  logic [VW-1:0] best_value_r;
  logic [31:0]   best_life_r;
  logic [31:0]   best_start_r;

  logic [1:0]    res_status_r;
  logic [63:0]   res_value_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [63:0]   out_value_r;

  logic          wr_en;
  logic          hit;
  logic          expired;
  logic [31:0]   age;
  logic [3:0]    nbytes;
  logic [VW-1:0] masked;

  assign wr_en = ctl.set_probe && !valid_r[idx_r];

  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.slot_free = !valid_r[idx_r];
  assign stat.scan_last = (idx_r == IW'(CAPACITY - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  // strict greater keeps the lowest slot among equal orders
  assign hit = rd_act_r && rd_vld_r && (rd_key_r == key_r) &&
               (!best_found_r || (rd_order_r > best_order_r));

  assign age     = elapsed_r - best_start_r;
  assign expired = (age >= best_life_r);
  assign nbytes  = (limit_r > VB4) ? VB4 : limit_r;

  always_comb begin
    for (int b = 0; b < VALUE_BYTES; b++) begin
      masked[8*b +: 8] = (4'(b) < nbytes) ? best_value_r[8*b +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[idx_r]   <= key_r;
      mem_value[idx_r] <= value_r;
      mem_life[idx_r]  <= life_r;
      mem_start[idx_r] <= elapsed_r;
      mem_order[idx_r] <= serial_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r   <= mem_key[idx_r];
    rd_value_r <= mem_value[idx_r];
    rd_life_r  <= mem_life[idx_r];
    rd_start_r <= mem_start[idx_r];
    rd_order_r <= mem_order[idx_r];
    rd_vld_r   <= valid_r[idx_r];
    rd_idx_r   <= idx_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      count_r      <= '0;
      elapsed_r    <= '0;
      serial_r     <= '0;
      idx_r        <= '0;
      rd_act_r     <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_act_r <= ctl.get_issue;
      if (ctl.load) begin
        idx_r        <= '0;
        best_found_r <= 1'b0;
      end else if (ctl.set_probe || ctl.get_issue) begin
        idx_r <= idx_r + IW'(1);
      end
      if (hit) begin
        best_found_r <= 1'b1;
      end
      if (ctl.tick) begin
        elapsed_r <= elapsed_r + 32'd1;
      end
      if (wr_en) begin
        valid_r[idx_r] <= 1'b1;
        count_r        <= count_r + CW'(1);
        serial_r       <= serial_r + 32'd1;
      end
      if (ctl.get_check && best_found_r && expired) begin
        valid_r[best_idx_r] <= 1'b0;
        if (count_r != '0) begin
          count_r <= count_r - CW'(1);
        end
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r   <= in_key;
      value_r <= in_new_value[VW-1:0];
      life_r  <= in_lifespan;
      limit_r <= in_byte_limit;
    end
    if (hit) begin
      best_idx_r   <= rd_idx_r;
      best_order_r <= rd_order_r;
      best_value_r <= rd_value_r;
      best_life_r  <= rd_life_r;
      best_start_r <= rd_start_r;
    end
    priority if (ctl.res_full) begin
      res_status_r <= ekv_pkg::ST_FULL;
      res_value_r  <= '0;
    end else if (ctl.res_ok) begin
      res_status_r <= ekv_pkg::ST_OK;
      res_value_r  <= '0;
    end else if (ctl.get_check) begin
      priority if (!best_found_r) begin
        res_status_r <= ekv_pkg::ST_NOT_FOUND;
        res_value_r  <= '0;
      end else if (expired) begin
        res_status_r <= ekv_pkg::ST_EXPIRED;
        res_value_r  <= '0;
      end else begin
        res_status_r <= ekv_pkg::ST_OK;
        res_value_r  <= 64'(masked);
      end
    end
    if (ctl.out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

endmodule

// ----- design/expiring_key_value_table.sv -----
// ----------------------------------------------------------------------------
// expiring_key_value_table: key/value table with per-entry time to live
// Set stores into the first free slot, get returns the newest entry with
// the key or expires it, tick advances the seconds count.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  in_cmd, in_key, in_new_value, in_lifespan,
//                                 in_byte_limit
//   out      out_valid/ out_ready out_status, out_read_value
//
// One command at a time. Get takes a scan of every slot through the entry
// memory read port, then compare, judge and hand-off; set scans up to the
// first free slot, then hands off; tick, unused commands and set on a full
// table go straight to the hand-off.
// A new beat is taken while the previous result waits in the output
// register; a stalled output only holds the next result in its last step.
// Synchronous reset clears all valid bits and counters at once.
// ----------------------------------------------------------------------------
module expiring_key_value_table #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic [63:0] in_new_value,
  input  logic [31:0] in_lifespan,
  input  logic [3:0]  in_byte_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_value
);

  ekv_pkg::ekv_ctl_t  ctl;
  ekv_pkg::ekv_stat_t stat;

  ekv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ekv_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .in_key         (in_key),
    .in_new_value   (in_new_value),
    .in_lifespan    (in_lifespan),
    .in_byte_limit  (in_byte_limit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value)
  );

  // one command in flight: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input beat taken while a command is in flight");

  // only a successful get carries a value
  a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ekv_pkg::ST_OK) |-> (out_read_value == 64'd0))
    else $error("nonzero value on a failed command");

  // a tick with a free output register finishes ok through the finish state and the output register
  a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == ekv_pkg::CMD_TICK) &&
    (!out_valid || out_ready)
    |=> ##1 (out_valid && (out_status == ekv_pkg::ST_OK)))
    else $error("tick result missing");

endmodule
